@@ hdl/ocd_pkg.sv @@
`timescale 1ns / 1ps

package ocd_pkg;

   // Rounded Rec.709 luma: (2126*R + 7152*G + 722*B + 5000) / 10000.
   localparam int unsigned LUMA_RED_COEF   = 2126;
   localparam int unsigned LUMA_GREEN_COEF = 7152;
   localparam int unsigned LUMA_BLUE_COEF  = 722;
   localparam int unsigned LUMA_ROUND      = 5000;
   localparam int unsigned LUMA_DIVISOR    = 10000;

   localparam int LUMA_NUM_W  = 22;
   localparam int LUMA_W      = 8;
   localparam int LUMA_SHIFT  = 36;
   localparam int LUMA_RECIP_W = 23;
   localparam int LUMA_PROD_W = LUMA_NUM_W + LUMA_RECIP_W;

   // The reciprocal is exact for every numerator below 2**22.
   localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP =
      LUMA_RECIP_W'(((64'd1 << LUMA_SHIFT) + 64'(LUMA_DIVISOR) - 64'd1) / 64'(LUMA_DIVISOR));

   localparam int SUM_W    = 12;
   localparam int COUNT_W  = 5;
   localparam int HIST_W   = 13;
   localparam int ROT_W    = 4;
   localparam int HEIGHT_W = 4;
   localparam int CODE_W   = 4;

   localparam logic [7:0] THRESHOLD_RESET = 8'd80;

   localparam logic [HIST_W-1:0] HIST_CMD_MASK   = 13'h1faa;
   localparam logic [HIST_W-1:0] HIST_CMD_LEADIN = 13'h02aa;
   localparam logic [HIST_W-1:0] HIST_TEST_A     = 13'h1555;
   localparam logic [HIST_W-1:0] HIST_TEST_B     = 13'h0aaa;
   localparam logic [HIST_W-1:0] HIST_ALL_ONES   = 13'h1fff;

   localparam logic [CODE_W-1:0] CMD_NONE     = 4'd0;
   localparam logic [CODE_W-1:0] CMD_RESET    = 4'd1;
   localparam logic [CODE_W-1:0] CMD_DOWN_ONE = 4'd2;
   localparam logic [CODE_W-1:0] CMD_ROT_FWD  = 4'd4;
   localparam logic [CODE_W-1:0] CMD_UP_TWO   = 4'd5;
   localparam logic [CODE_W-1:0] CMD_CLOSE    = 4'd6;
   localparam logic [CODE_W-1:0] CMD_ROT_BACK = 4'd8;
   localparam logic [CODE_W-1:0] CMD_OPEN     = 4'd10;
   localparam logic [CODE_W-1:0] CMD_UP_ONE   = 4'd12;
   localparam logic [CODE_W-1:0] CMD_DOWN_TWO = 4'd13;

   // One frame decision handed to the command unit.
   typedef struct packed {
      logic step;
      logic bright;
   } decision_type;

   // Result word fields; the last member sits in the lowest bits.
   typedef struct packed {
      logic             grip_open;
      logic [2:0]       lift_level;
      logic [ROT_W-1:0] arm_rotation;
      logic [CODE_W-1:0] command_code;
      logic             command_valid;
      logic             frame_bright;
   } rsp_fields_type;

   localparam int RSP_FIELDS_W = $bits(rsp_fields_type);
   localparam int RSP_DATA_W   = 16;

endpackage

@@ hdl/ocd_command.sv @@
`timescale 1ns / 1ps

module ocd_command #(
   parameter int HEIGHT_MAX     = 5,
   parameter int ROTATION_STEPS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ocd_pkg::decision_type   decision,
   output ocd_pkg::rsp_fields_type result
);

   logic [ocd_pkg::HIST_W-1:0]   hist_ff;
   logic [ocd_pkg::HIST_W-1:0]   hist_in;
   logic [ocd_pkg::HIST_W-1:0]   hist_shift;
   logic [ocd_pkg::ROT_W-1:0]    rot_ff;
   logic [ocd_pkg::ROT_W-1:0]    rot_in;
   logic [ocd_pkg::HEIGHT_W-1:0] height_ff;
   logic [ocd_pkg::HEIGHT_W-1:0] height_in;
   logic                         hands_ff;
   logic                         hands_in;
   logic                         is_test;
   logic                         match;
   logic [ocd_pkg::CODE_W-1:0]   code;
   logic [ocd_pkg::HEIGHT_W:0]   height_up_two;

   localparam logic [ocd_pkg::HEIGHT_W-1:0] HEIGHT_TOP = ocd_pkg::HEIGHT_W'(HEIGHT_MAX);
   localparam logic [ocd_pkg::ROT_W-1:0]    ROT_LAST   = ocd_pkg::ROT_W'(ROTATION_STEPS - 1);

   always_comb begin
      hist_shift = {hist_ff[ocd_pkg::HIST_W-2:0], decision.bright};
      is_test    = (hist_shift == ocd_pkg::HIST_TEST_A) || (hist_shift == ocd_pkg::HIST_TEST_B);
      match      = is_test ||
                   ((hist_shift & ocd_pkg::HIST_CMD_MASK) == ocd_pkg::HIST_CMD_LEADIN);
      // Command bits sit between the alternating clock bits of the pattern.
      if (is_test || !match) begin
         code = ocd_pkg::CMD_NONE;
      end else begin
         code = {hist_shift[6], hist_shift[4], hist_shift[2], hist_shift[0]};
      end

      hist_in       = match ? ocd_pkg::HIST_ALL_ONES : hist_shift;
      rot_in        = rot_ff;
      height_in     = height_ff;
      hands_in      = hands_ff;
      height_up_two = {1'b0, height_ff} + 5'd2;

      case (code)
         ocd_pkg::CMD_RESET: begin
            rot_in    = '0;
            height_in = HEIGHT_TOP;
            hands_in  = 1'b1;
         end
         ocd_pkg::CMD_DOWN_ONE: begin
            if (height_ff != '0) height_in = height_ff - 4'd1;
         end
         ocd_pkg::CMD_ROT_FWD: begin
            rot_in = (rot_ff == ROT_LAST) ? '0 : rot_ff + 4'd1;
         end
         ocd_pkg::CMD_UP_TWO: begin
            height_in = (height_up_two > {1'b0, HEIGHT_TOP}) ? HEIGHT_TOP
                                                             : height_up_two[3:0];
         end
         ocd_pkg::CMD_CLOSE: begin
            hands_in = 1'b0;
         end
         ocd_pkg::CMD_ROT_BACK: begin
            rot_in = (rot_ff == '0) ? ROT_LAST : rot_ff - 4'd1;
         end
         ocd_pkg::CMD_OPEN: begin
            hands_in = 1'b1;
         end
         ocd_pkg::CMD_UP_ONE: begin
            if (height_ff < HEIGHT_TOP) height_in = height_ff + 4'd1;
         end
         ocd_pkg::CMD_DOWN_TWO: begin
            height_in = (height_ff >= 4'd2) ? height_ff - 4'd2 : '0;
         end
         default: begin
         end
      endcase

      result.frame_bright  = decision.bright;
      result.command_valid = match;
      result.command_code  = code;
      result.arm_rotation  = rot_in;
      result.lift_level    = height_in[2:0];
      result.grip_open     = hands_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         rot_ff    <= '0;
         height_ff <= '0;
         hands_ff  <= 1'b1;
      end else if (decision.step) begin
         hist_ff   <= hist_in;
         rot_ff    <= rot_in;
         height_ff <= height_in;
         hands_ff  <= hands_in;
      end
   end

endmodule

@@ hdl/optical_command_decoder.sv @@
`timescale 1ns / 1ps
// Each end-of-frame sample leaves the result register as one result word.
// Throughput: one sample word per cycle while rsp_tready keeps up; a five-stage pipeline of
// input register, luma numerator, reciprocal multiply, frame accumulator and command/result register.
// Reset is synchronous and active high: it empties the pipeline, clears the sums,
// history and targets (hands open) and sets the brightness threshold to 80.
module optical_command_decoder #(
   parameter int HEIGHT_MAX        = 5,
   parameter int ROTATION_STEPS    = 12,
   parameter int SAMPLES_PER_FRAME = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic        req_tuser,   // in_frame
   input  logic        req_tlast,   // end_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_bright[0], command_valid[1], command_code[5:2], arm_rotation[9:6],
   // lift_level[12:10], grip_open[13], zero[15:14]
   output logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0] threshold_ff;

   logic        s1_valid_ff;
   logic [23:0] s1_pix_ff;
   logic        s1_in_frame_ff;
   logic        s1_eof_ff;

   logic                          s2_valid_ff;
   logic [ocd_pkg::LUMA_NUM_W-1:0] s2_num_ff;
   logic [ocd_pkg::LUMA_NUM_W-1:0] s2_num_in;
   logic                          s2_in_frame_ff;
   logic                          s2_eof_ff;

   logic                           s3_valid_ff;
   logic [ocd_pkg::LUMA_W-1:0]     s3_luma_ff;
   logic [ocd_pkg::LUMA_PROD_W-1:0] s3_prod_in;
   logic                           s3_in_frame_ff;
   logic                           s3_eof_ff;

   logic [ocd_pkg::SUM_W-1:0]   sum_ff;
   logic [ocd_pkg::SUM_W-1:0]   sum_in;
   logic [ocd_pkg::COUNT_W-1:0] count_ff;
   logic [ocd_pkg::COUNT_W-1:0] count_in;
   logic                        take;
   logic [ocd_pkg::SUM_W:0]     limit;
   logic                        s4_valid_ff;
   logic                        s4_bright_ff;
   logic                        s4_bright_in;

   logic                    rsp_valid_ff;
   ocd_pkg::rsp_fields_type rsp_data_ff;
   ocd_pkg::rsp_fields_type result;
   ocd_pkg::decision_type   decision;

   logic s1_en, s2_en, s3_en, s4_en, s5_en;

   // Each stage moves when its successor is empty or moving too.
   assign s5_en      = !rsp_valid_ff || rsp_tready;
   assign s4_en      = !s4_valid_ff || s5_en;
   assign s3_en      = !s3_valid_ff || s4_en;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ocd_pkg::RSP_DATA_W - ocd_pkg::RSP_FIELDS_W)'(0), rsp_data_ff};

   always_comb begin
      s2_num_in = ocd_pkg::LUMA_NUM_W'(s1_pix_ff[7:0])   * ocd_pkg::LUMA_NUM_W'(ocd_pkg::LUMA_RED_COEF)
                + ocd_pkg::LUMA_NUM_W'(s1_pix_ff[15:8])  * ocd_pkg::LUMA_NUM_W'(ocd_pkg::LUMA_GREEN_COEF)
                + ocd_pkg::LUMA_NUM_W'(s1_pix_ff[23:16]) * ocd_pkg::LUMA_NUM_W'(ocd_pkg::LUMA_BLUE_COEF)
                + ocd_pkg::LUMA_NUM_W'(ocd_pkg::LUMA_ROUND);
      // Division by 10000 as a multiply by its scaled reciprocal.
      s3_prod_in = ocd_pkg::LUMA_PROD_W'(s2_num_ff) * ocd_pkg::LUMA_PROD_W'(ocd_pkg::LUMA_RECIP);
   end

   always_comb begin
      take = s3_in_frame_ff && (count_ff < ocd_pkg::COUNT_W'(SAMPLES_PER_FRAME));
      if (take) begin
         sum_in   = sum_ff + ocd_pkg::SUM_W'(s3_luma_ff);
         count_in = count_ff + 5'd1;
      end else begin
         sum_in   = sum_ff;
         count_in = count_ff;
      end
      // Comparing the sum with threshold times count avoids dividing for the average.
      limit        = (ocd_pkg::SUM_W + 1)'(threshold_ff) * (ocd_pkg::SUM_W + 1)'(count_in);
      s4_bright_in = (count_in != '0) && ({1'b0, sum_in} >= limit);
   end

   assign decision.step   = s4_valid_ff && s5_en;
   assign decision.bright = s4_bright_ff;

   ocd_command #(
      .HEIGHT_MAX     (HEIGHT_MAX),
      .ROTATION_STEPS (ROTATION_STEPS)
   ) u_command (
      .clock    (clock),
      .reset    (reset),
      .decision (decision),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ocd_pkg::THRESHOLD_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_wr_en) threshold_ff <= csr_wr_data;
         if (s1_en) s1_valid_ff <= req_tvalid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         // Only an end-of-frame word leaves the accumulator as a decision.
         if (s4_en) s4_valid_ff <= s3_valid_ff && s3_eof_ff;
         if (s5_en) rsp_valid_ff <= s4_valid_ff;
         if (s3_valid_ff && s4_en) begin
            if (s3_eof_ff) begin
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_in;
               count_ff <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_pix_ff      <= req_tdata;
         s1_in_frame_ff <= req_tuser;
         s1_eof_ff      <= req_tlast;
      end
      if (s2_en) begin
         s2_num_ff      <= s2_num_in;
         s2_in_frame_ff <= s1_in_frame_ff;
         s2_eof_ff      <= s1_eof_ff;
      end
      if (s3_en) begin
         s3_luma_ff     <= s3_prod_in[ocd_pkg::LUMA_SHIFT +: ocd_pkg::LUMA_W];
         s3_in_frame_ff <= s2_in_frame_ff;
         s3_eof_ff      <= s2_eof_ff;
      end
      if (s4_en) s4_bright_ff <= s4_bright_in;
      if (decision.step) rsp_data_ff <= result;
   end

endmodule

@@ hdl/ocd_checker.sv @@
`timescale 1ns / 1ps

module ocd_checker #(
   parameter int ROTATION_STEPS = 12
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // A nonzero command code only comes with a pattern match.
   a_code_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[5:2] != 4'd0) |-> rsp_tdata[1])
      else $error("command code without command_valid");

   // Every accepted command pattern ends in the bit just decided, which is also code bit 0.
   a_code_lsb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] && (rsp_tdata[5:2] != 4'd0) |-> rsp_tdata[2] == rsp_tdata[0])
      else $error("command code bit 0 disagrees with frame brightness");

   // The target rotation stays within the rotation step count.
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:6] < ROTATION_STEPS)
      else $error("arm rotation out of range");

endmodule

bind optical_command_decoder ocd_checker #(.ROTATION_STEPS(ROTATION_STEPS)) u_ocd_checker (.*);

@@ bench/optical_command_decoder_test.sv @@
`timescale 1ns / 1ps
module optical_command_decoder_test;

   localparam int HEIGHT_TOP     = 5;
   localparam int ROT_STEPS      = 12;
   localparam int FRAME_SAMPLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MISMATCH_PRINTS = 40;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_frame;
      logic       frame_end;
      logic       hold;
   } sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
   logic        req_tuser = 1'b0; // in_frame
   logic        req_tlast = 1'b0; // end_of_frame
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // frame_bright[0], command_valid[1], command_code[5:2], arm_rotation[9:6],
   // lift_level[12:10], grip_open[13], zero[15:14]
   logic [15:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   // Shadow copy of the decoder state.
   logic [7:0]  bright_level = ocd_pkg::THRESHOLD_RESET;
   logic [11:0] luma_total = '0;
   logic [4:0]  counted = '0;
   logic [12:0] frame_history = '0;
   logic [3:0]  rotation_now = '0;
   logic [3:0]  height_now = '0;
   logic        hands_now = 1'b1;

   sample_type              pending_samples[$];
   ocd_pkg::rsp_fields_type expected_status[$];
   sample_type              on_bus;
   idle_mode_type           idle_mode = IDLE_NONE;
   int             error_count = 0;
   int             stim_count = 0;
   int             sequence_count = 0;
   logic [3:0]     previous_code = ocd_pkg::CMD_NONE;
   logic           hold_next = 1'b0;
   int             quiet_cycles = 0;

   optical_command_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned num;
      num = r * ocd_pkg::LUMA_RED_COEF + g * ocd_pkg::LUMA_GREEN_COEF
          + b * ocd_pkg::LUMA_BLUE_COEF + ocd_pkg::LUMA_ROUND;
      return 8'(num / ocd_pkg::LUMA_DIVISOR);
   endfunction

   task automatic update_targets(logic [3:0] code);
      case (code)
         ocd_pkg::CMD_RESET: begin
            rotation_now = '0;
            height_now = 4'(HEIGHT_TOP);
            hands_now = 1'b1;
         end
         ocd_pkg::CMD_DOWN_ONE: begin
            if (height_now > 0) height_now = height_now - 4'd1;
         end
         ocd_pkg::CMD_DOWN_TWO: begin
            height_now = (height_now >= 4'd2) ? height_now - 4'd2 : 4'd0;
         end
         ocd_pkg::CMD_UP_ONE: begin
            if (height_now < HEIGHT_TOP) height_now = height_now + 4'd1;
         end
         ocd_pkg::CMD_UP_TWO: begin
            height_now = (height_now + 2 > HEIGHT_TOP) ? 4'(HEIGHT_TOP) : height_now + 4'd2;
         end
         ocd_pkg::CMD_ROT_FWD: begin
            rotation_now = 4'((rotation_now + 1) % ROT_STEPS);
         end
         ocd_pkg::CMD_ROT_BACK: begin
            rotation_now = 4'((rotation_now + ROT_STEPS - 1) % ROT_STEPS);
         end
         ocd_pkg::CMD_CLOSE: begin
            hands_now = 1'b0;
         end
         ocd_pkg::CMD_OPEN: begin
            hands_now = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   // Follows one accepted sample word and queues the status it should produce.
   task automatic decode_sample(sample_type s);
      ocd_pkg::rsp_fields_type status;
      logic           bright;
      logic           hit;
      logic [3:0]     code;
      if (s.in_frame && counted < FRAME_SAMPLES) begin
         luma_total = luma_total + 12'(luma_of(s.red, s.green, s.blue));
         counted = counted + 5'd1;
      end
      if (!s.frame_end) return;
      bright = (counted != 0) && (int'(luma_total) >= int'(bright_level) * int'(counted));
      luma_total = '0;
      counted = '0;
      frame_history = {frame_history[11:0], bright};
      hit = 1'b0;
      code = ocd_pkg::CMD_NONE;
      if (frame_history == ocd_pkg::HIST_TEST_A || frame_history == ocd_pkg::HIST_TEST_B) begin
         hit = 1'b1;
      end else if ((frame_history & ocd_pkg::HIST_CMD_MASK) == ocd_pkg::HIST_CMD_LEADIN) begin
         hit = 1'b1;
         code = {frame_history[6], frame_history[4], frame_history[2], frame_history[0]};
      end
      if (hit) begin
         frame_history = ocd_pkg::HIST_ALL_ONES;
         update_targets(code);
      end
      status.frame_bright = bright;
      status.command_valid = hit;
      status.command_code = code;
      status.arm_rotation = rotation_now;
      status.lift_level = height_now[2:0];
      status.grip_open = hands_now;
      expected_status.push_back(status);
   endtask

   function automatic bit sender_rests();
      if (idle_mode == IDLE_SENDER) return $urandom_range(99, 0) < 54;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99, 0) < 17;
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls();
      if (idle_mode == IDLE_RECEIVER) return $urandom_range(99, 0) < 54;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99, 0) < 17;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) decode_sample(on_bus);
         if (!req_tvalid || req_tready) begin
            // A held word waits until every status already owed has come back.
            if (pending_samples.size() != 0 && !sender_rests()
                && !(pending_samples[0].hold && expected_status.size() != 0)) begin
               on_bus = pending_samples.pop_front();
               req_tdata <= {on_bus.blue, on_bus.green, on_bus.red};
               req_tuser <= on_bus.in_frame;
               req_tlast <= on_bus.frame_end;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(string name, int want, int got);
      error_count++;
      if (error_count <= MISMATCH_PRINTS)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
   endtask

   always @(posedge clock) begin
      ocd_pkg::rsp_fields_type got;
      ocd_pkg::rsp_fields_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[ocd_pkg::RSP_FIELDS_W-1:0];
            if (expected_status.size() == 0) begin
               error_count++;
               if (error_count <= MISMATCH_PRINTS)
                  $display("%0t: unexpected status word, expected none, got %h",
                           $time, rsp_tdata);
            end else begin
               want = expected_status.pop_front();
               if (got.frame_bright !== want.frame_bright)
                  report_field("frame_bright", want.frame_bright, got.frame_bright);
               if (got.command_valid !== want.command_valid)
                  report_field("command_valid", want.command_valid, got.command_valid);
               if (got.command_code !== want.command_code)
                  report_field("command_code", want.command_code, got.command_code);
               if (got.arm_rotation !== want.arm_rotation)
                  report_field("arm_rotation", want.arm_rotation, got.arm_rotation);
               if (got.lift_level !== want.lift_level)
                  report_field("lift_level", want.lift_level, got.lift_level);
               if (got.grip_open !== want.grip_open)
                  report_field("grip_open", want.grip_open, got.grip_open);
            end
         end
         rsp_tready <= !receiver_stalls();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("optical_command_decoder_test: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic push_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic in_frame, logic frame_end);
      sample_type s;
      s.red = r;
      s.green = g;
      s.blue = b;
      s.in_frame = in_frame;
      s.frame_end = frame_end;
      s.hold = hold_next;
      hold_next = 1'b0;
      pending_samples.push_back(s);
      stim_count++;
   endtask

   task automatic push_stray(logic frame_end);
      push_sample($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0),
                  1'b0, frame_end);
   endtask

   // Picks a pixel whose luma lands on the wanted side of the threshold.
   task automatic pick_pixel(logic want, output logic [7:0] r, output logic [7:0] g,
                             output logic [7:0] b);
      logic [7:0] v;
      repeat (6) begin
         r = $urandom_range(255, 0);
         g = $urandom_range(255, 0);
         b = $urandom_range(255, 0);
         if ((luma_of(r, g, b) >= bright_level) == want) return;
      end
      v = want ? 8'($urandom_range(255, bright_level)) : 8'($urandom_range(bright_level - 1, 0));
      r = v;
      g = v;
      b = v;
   endtask

   task automatic push_frame(logic want);
      int         n;
      bit         stray_end;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 5) : $urandom_range(3, 1);
      // With a zero threshold only a frame with nothing counted is dark.
      if (!want && bright_level == 0) n = 0;
      stray_end = (n == 0) || ($urandom_range(3, 0) == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(5, 0) == 0) push_stray(1'b0);
         pick_pixel(want, r, g, b);
         push_sample(r, g, b, 1'b1, !stray_end && i == n - 1);
      end
      if (stray_end) push_stray(1'b1);
   endtask

   task automatic push_history(logic [12:0] bits);
      for (int i = 12; i >= 0; i--) push_frame(bits[i]);
   endtask

   task automatic push_noise_frame();
      int n;
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++)
         push_sample($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0),
                     $urandom_range(1, 0), i == n - 1);
   endtask

   task automatic fill_phase(int wanted, bit with_holds);
      int         first;
      int         pick;
      logic [3:0] code;
      first = stim_count;
      while (stim_count - first < wanted) begin
         if (with_holds && (stim_count == first || $urandom_range(2, 0) == 0)) hold_next = 1'b1;
         pick = $urandom_range(9, 0);
         if (pick < 7) begin
            // The first sequences walk through every code, later ones tend to repeat.
            if (sequence_count < 16) code = 4'(sequence_count);
            else if ($urandom_range(1, 0) == 0) code = previous_code;
            else code = 4'($urandom_range(15, 0));
            previous_code = code;
            sequence_count++;
            push_history({3'b000, 1'b1, 1'b0, 1'b1, code[3], 1'b1, code[2], 1'b1,
                          code[1], 1'b1, code[0]});
         end else if (pick == 7) begin
            push_history($urandom_range(1, 0) ? ocd_pkg::HIST_TEST_A : ocd_pkg::HIST_TEST_B);
         end else begin
            repeat ($urandom_range(3, 1)) push_noise_frame();
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_tvalid || expected_status.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bright_level = value;
   endtask

   initial begin
      int levels[8];
      levels = '{0, 255, 128, -1, 80, 1, 254, -1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      push_sample(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
      push_sample(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
      push_sample(8'd255, 8'd0, 8'd0, 1'b0, 1'b1);
      push_sample(8'd0, 8'd255, 8'd0, 1'b1, 1'b0);
      push_sample(8'd0, 8'd0, 8'd255, 1'b0, 1'b1);
      // Sixteen black samples fill the frame, so the white one after them is dropped.
      repeat (FRAME_SAMPLES) push_sample(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
      push_sample(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_threshold(levels[p] < 0 ? 8'($urandom_range(255, 0)) : 8'(levels[p]));
         idle_mode = idle_mode_type'(p % 4);
         fill_phase(170, p == 2);
      end
      wait_idle();
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("optical_command_decoder_test: done, clean");
      end else begin
         $display("optical_command_decoder_test: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/ocd_pkg.sv
hdl/ocd_command.sv
hdl/optical_command_decoder.sv
hdl/ocd_checker.sv
bench/optical_command_decoder_test.sv
